/* rtl/core/pct_pkg.sv */
// ----------------------------------------------------------------------------
// pct_pkg
// Shared pair codes, register map constants and control structs for the
// 2D primitive collision test.
// ----------------------------------------------------------------------------
`default_nettype none

package pct_pkg;

  typedef enum logic [3:0] {
    PCT_PT_PT     = 4'd0,
    PCT_PT_SEG    = 4'd1,
    PCT_PT_CIRC   = 4'd2,
    PCT_PT_RECT   = 4'd3,
    PCT_SEG_SEG   = 4'd4,
    PCT_SEG_CIRC  = 4'd5,
    PCT_SEG_RECT  = 4'd6,
    PCT_CIRC_CIRC = 4'd7,
    PCT_CIRC_RECT = 4'd8,
    PCT_RECT_RECT = 4'd9
  } pct_pair_t;

  localparam int          EPS_W     = 16;
  localparam logic [15:0] EPS_RESET = 16'd1;
  localparam logic        REG_EPS   = 1'b0;

  typedef struct packed {
    logic full;
    logic empty;
  } pct_qstat_t;

endpackage

`default_nettype wire

/* rtl/core/pct_front.sv */
// ----------------------------------------------------------------------------
// pct_front
// Input stage: takes a query, sign-extends the shape fields and forms the
// doubled rectangle edges, then hands the classified item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_front import pct_pkg::*; #(
  parameter int W  = 32,
  parameter int EW = W + 4,
  parameter int IW = 4 + 16 * EW
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [3:0]          in_req_type,
  input  wire  signed [W-1:0] in_a_x0,
  input  wire  signed [W-1:0] in_a_y0,
  input  wire  signed [W-1:0] in_a_x1,
  input  wire  signed [W-1:0] in_a_y1,
  input  wire  signed [W-1:0] in_b_x0,
  input  wire  signed [W-1:0] in_b_y0,
  input  wire  signed [W-1:0] in_b_x1,
  input  wire  signed [W-1:0] in_b_y1,
  input  pct_qstat_t          q_st,
  output logic                push,
  output logic                f_valid,
  output logic [IW-1:0]       item
);

  logic signed [EW-1:0] ax, ay, ax1, ay1, bx, by, bx1, by1;
  logic signed [EW-1:0] axl, axh, ayl, ayh, bxl, bxh, byl, byh;
  logic                 fv_r;
  logic [IW-1:0]        item_r, item_nxt;

  assign ax  = EW'(in_a_x0);
  assign ay  = EW'(in_a_y0);
  assign ax1 = EW'(in_a_x1);
  assign ay1 = EW'(in_a_y1);
  assign bx  = EW'(in_b_x0);
  assign by  = EW'(in_b_y0);
  assign bx1 = EW'(in_b_x1);
  assign by1 = EW'(in_b_y1);

  // rectangle edges on doubled coordinates: 2c -+ size
  assign axl = (ax <<< 1) - ax1;
  assign axh = (ax <<< 1) + ax1;
  assign ayl = (ay <<< 1) - ay1;
  assign ayh = (ay <<< 1) + ay1;
  assign bxl = (bx <<< 1) - bx1;
  assign bxh = (bx <<< 1) + bx1;
  assign byl = (by <<< 1) - by1;
  assign byh = (by <<< 1) + by1;

  assign item_nxt = {in_req_type, ax, ay, ax1, ay1, bx, by, bx1, by1,
                     axl, axh, ayl, ayh, bxl, bxh, byl, byh};

  assign in_stall = fv_r && q_st.full;
  assign push     = fv_r && !q_st.full;
  assign f_valid  = fv_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (!in_stall) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pct_queue.sv */
// ----------------------------------------------------------------------------
// pct_queue
// Short FIFO between front and back so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_queue import pct_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire  [WIDTH-1:0] wdata,
  input  wire              pop,
  output logic [WIDTH-1:0] rdata,
  output pct_qstat_t       stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;

  assign rdata      = mem_r[rp_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pct_segseg.sv */
// ----------------------------------------------------------------------------
// pct_segseg
// Two-stage segment against segment test: cross products registered, then
// the near-parallel bounding-box rule or the two ratio range checks.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_segseg #(
  parameter int CW  = 36,
  parameter int THW = 34
) (
  input  wire                  clk,
  input  wire                  en,
  input  wire  signed [CW-1:0] x1,
  input  wire  signed [CW-1:0] y1,
  input  wire  signed [CW-1:0] x2,
  input  wire  signed [CW-1:0] y2,
  input  wire  signed [CW-1:0] x3,
  input  wire  signed [CW-1:0] y3,
  input  wire  signed [CW-1:0] x4,
  input  wire  signed [CW-1:0] y4,
  input  wire  [THW-1:0]       thr,
  output logic                 hit
);

  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int CMW = ((PW + 1) > THW ? (PW + 1) : THW) + 1;

  function automatic logic inspan(input logic signed [CW-1:0] a, b, v);
    return (v >= a || v >= b) && (v <= a || v <= b);
  endfunction

  function automatic logic unit_ratio(input logic signed [PW:0] n, c);
    if (c >= 0) return (n >= 0) && (n <= c);
    return (n >= c) && (n <= 0);
  endfunction

  logic signed [DW-1:0] ax, ay, bx, by, cx, cy;
  logic                 box;
  logic signed [PW-1:0] pca_r, pcb_r, p1a_r, p1b_r, p2a_r, p2b_r;
  logic                 box_r, hit_r;
  logic [THW-1:0]       thr_r;
  logic signed [PW:0]   c, n1, n2, absc;
  logic                 near0;

  assign ax = DW'(x2) - DW'(x1);
  assign ay = DW'(y2) - DW'(y1);
  assign bx = DW'(x4) - DW'(x3);
  assign by = DW'(y4) - DW'(y3);
  assign cx = DW'(x1) - DW'(x3);
  assign cy = DW'(y1) - DW'(y3);

  assign box = (inspan(x1, x2, x3) && inspan(y1, y2, y3)) ||
               (inspan(x1, x2, x4) && inspan(y1, y2, y4)) ||
               (inspan(x3, x4, x1) && inspan(y3, y4, y1)) ||
               (inspan(x3, x4, x2) && inspan(y3, y4, y2));

  always_ff @(posedge clk) begin
    if (en) begin
      pca_r <= ax * by;
      pcb_r <= ay * bx;
      p1a_r <= bx * cy;
      p1b_r <= by * cx;
      p2a_r <= ax * cy;
      p2b_r <= ay * cx;
      box_r <= box;
      thr_r <= thr;
    end
  end

  assign c     = pca_r - pcb_r;
  assign n1    = p1a_r - p1b_r;
  assign n2    = p2a_r - p2b_r;
  assign absc  = (c < 0) ? -c : c;
  assign near0 = CMW'($unsigned(absc)) <= CMW'(thr_r);

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= near0 ? box_r : (unit_ratio(n1, c) && unit_ratio(n2, c));
    end
  end

  assign hit = hit_r;

endmodule

`default_nettype wire

/* rtl/core/pct_back.sv */
// ----------------------------------------------------------------------------
// pct_back
// Execution pipeline: products, then compares and the second-order products
// of the segment-circle case, then the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_back import pct_pkg::*; #(
  parameter int W    = 32,
  parameter int FRAC = 16,
  parameter int EW   = W + 4,
  parameter int IW   = 4 + 16 * EW
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire  [EPS_W-1:0] eps,
  input  pct_qstat_t       q_st,
  input  wire  [IW-1:0]    q_rdata,
  output logic             q_pop,
  output logic             out_valid,
  input  wire              out_stall,
  output logic             out_hit
);

  localparam int PW  = 2 * EW;
  localparam int THW = EPS_W + FRAC + 2;
  localparam int HW  = (PW + 2) / 2;
  localparam int MW  = 2 * HW;

  function automatic logic signed [EW-1:0] sabs(input logic signed [EW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic inspan(input logic signed [EW-1:0] a, b, v);
    return (v >= a || v >= b) && (v <= a || v <= b);
  endfunction

  logic signed [EW-1:0] u [16];
  pct_pair_t            t;
  logic                 adv;

  for (genvar k = 0; k < 16; k++) begin : g_unpack
    assign u[k] = q_rdata[IW-5-k*EW -: EW];
  end
  assign t = pct_pair_t'(q_rdata[IW-1 -: 4]);

  logic signed [EW-1:0] ax, ay, ax1, ay1, bx, by, bx1, by1;
  logic signed [EW-1:0] axl, axh, ayl, ayh, bxl, bxh, byl, byh;
  logic signed [EW-1:0] e, ax2, ay2;
  assign ax  = u[0];  assign ay  = u[1];  assign ax1 = u[2];  assign ay1 = u[3];
  assign bx  = u[4];  assign by  = u[5];  assign bx1 = u[6];  assign by1 = u[7];
  assign axl = u[8];  assign axh = u[9];  assign ayl = u[10]; assign ayh = u[11];
  assign bxl = u[12]; assign bxh = u[13]; assign byl = u[14]; assign byh = u[15];
  assign e   = EW'($signed({1'b0, eps}));
  assign ax2 = ax <<< 1;
  assign ay2 = ay <<< 1;

  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_st.empty;

  // ---- stage 1 ----
  logic c0, c3, c9, c1_vert, c1_horz, c1_need, c1_direct;
  logic signed [EW-1:0] dx1, dy1, dx5, dy5, qx, qy, lu, lv, lw;

  assign c0 = (ax == bx) && (ay == by);
  assign c3 = (bxl <= ax2) && (ax2 <= bxh) && (byl <= ay2) && (ay2 <= byh);
  assign c9 = (bxl <= axh) && (axl <= bxh) && (byl <= ayh) && (ayl <= byh);

  // point on segment: point a, segment b
  assign dx1       = bx1 - bx;
  assign dy1       = by1 - by;
  assign c1_vert   = sabs(bx - bx1) <= e;
  assign c1_horz   = sabs(by - by1) <= e;
  assign c1_direct = c1_vert ? (sabs(bx - ax) <= e) && inspan(by, by1, ay) :
                     c1_horz ? (sabs(by - ay) <= e) && inspan(bx, bx1, ax) : 1'b0;
  assign c1_need   = !c1_vert && !c1_horz && inspan(bx, bx1, ax);

  // circle-rect clamp, minimum edge first
  assign qx = (ax2 < bxl) ? bxl : ((ax2 > bxh) ? bxh : ax2);
  assign qy = (ay2 < byl) ? byl : ((ay2 > byh) ? byh : ay2);

  // shared squared-distance lane
  always_comb begin
    case (t)
      PCT_CIRC_CIRC: begin
        lu = bx - ax;  lv = by - ay;  lw = ax1 + bx1;
      end
      PCT_CIRC_RECT: begin
        lu = qx - ax2; lv = qy - ay2; lw = ax1 <<< 1;
      end
      default: begin
        lu = ax - bx;  lv = ay - by;  lw = bx1;
      end
    endcase
  end

  assign dx5 = ax1 - ax;
  assign dy5 = ay1 - ay;

  logic                 s1_v_r, s1_c0_r, s1_c3_r, s1_c9_r, s1_need_r, s1_dir_r;
  pct_pair_t            s1_t_r;
  logic signed [PW-1:0] p1a_r, p1b_r, p1c_r, lu_r, lv_r, lw_r;
  logic signed [PW-1:0] rr_r, sa_r, sb_r, ea_r, eb_r, da_r, db_r, na_r, nb_r, ka_r, kb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_t_r    <= t;
      s1_c0_r   <= c0;
      s1_c3_r   <= c3;
      s1_c9_r   <= c9;
      s1_need_r <= c1_need;
      s1_dir_r  <= c1_direct;
      p1a_r     <= dy1 * (ax - bx);
      p1b_r     <= (ay - by) * dx1;
      p1c_r     <= e * sabs(dx1);
      lu_r      <= lu * lu;
      lv_r      <= lv * lv;
      lw_r      <= lw * lw;
      rr_r      <= bx1 * bx1;
      sa_r      <= (ax - bx) * (ax - bx);
      sb_r      <= (ay - by) * (ay - by);
      ea_r      <= (ax1 - bx) * (ax1 - bx);
      eb_r      <= (ay1 - by) * (ay1 - by);
      da_r      <= dx5 * dx5;
      db_r      <= dy5 * dy5;
      na_r      <= (bx - ax) * dx5;
      nb_r      <= (by - ay) * dy5;
      ka_r      <= dx5 * (by - ay);
      kb_r      <= dy5 * (bx - ax);
    end
  end

  // ---- segment units (stages 1 and 2 inside) ----
  logic [THW-1:0]       thr_seg, thr_rect, thr0;
  logic signed [EW-1:0] s0x1, s0y1, s0x2, s0y2, s0x3, s0y3, s0x4, s0y4;
  logic signed [EW-1:0] sx2, sy2, ex2, ey2;
  logic [3:0]           ss;

  assign thr_seg  = THW'(eps) << FRAC;
  assign thr_rect = THW'(eps) << (FRAC + 2);
  assign sx2 = ax2;
  assign sy2 = ay2;
  assign ex2 = ax1 <<< 1;
  assign ey2 = ay1 <<< 1;

  always_comb begin
    if (t == PCT_SEG_SEG) begin
      s0x1 = ax;  s0y1 = ay;  s0x2 = ax1; s0y2 = ay1;
      s0x3 = bx;  s0y3 = by;  s0x4 = bx1; s0y4 = by1;
      thr0 = thr_seg;
    end else begin
      s0x1 = sx2; s0y1 = sy2; s0x2 = ex2; s0y2 = ey2;
      s0x3 = bxl; s0y3 = byl; s0x4 = bxh; s0y4 = byl;
      thr0 = thr_rect;
    end
  end

  pct_segseg #(.CW(EW), .THW(THW)) u_seg0 (
    .clk(clk), .en(adv), .x1(s0x1), .y1(s0y1), .x2(s0x2), .y2(s0y2),
    .x3(s0x3), .y3(s0y3), .x4(s0x4), .y4(s0y4), .thr(thr0), .hit(ss[0])
  );
  pct_segseg #(.CW(EW), .THW(THW)) u_seg1 (
    .clk(clk), .en(adv), .x1(sx2), .y1(sy2), .x2(ex2), .y2(ey2),
    .x3(bxh), .y3(byl), .x4(bxh), .y4(byh), .thr(thr_rect), .hit(ss[1])
  );
  pct_segseg #(.CW(EW), .THW(THW)) u_seg2 (
    .clk(clk), .en(adv), .x1(sx2), .y1(sy2), .x2(ex2), .y2(ey2),
    .x3(bxh), .y3(byh), .x4(bxl), .y4(byh), .thr(thr_rect), .hit(ss[2])
  );
  pct_segseg #(.CW(EW), .THW(THW)) u_seg3 (
    .clk(clk), .en(adv), .x1(sx2), .y1(sy2), .x2(ex2), .y2(ey2),
    .x3(bxl), .y3(byh), .x4(bxl), .y4(byl), .thr(thr_rect), .hit(ss[3])
  );

  // ---- stage 2 ----
  logic signed [PW:0] d1, abs_d1, lsum, ssum, esum, dd, nsum, cr, cra;
  logic               c1_hit, len_hit, pre, c5_end, c5_go;
  logic [MW-1:0]      cm, rm, dm;

  assign d1      = p1a_r - p1b_r;
  assign abs_d1  = (d1 < 0) ? -d1 : d1;
  assign c1_hit  = s1_dir_r || (s1_need_r && (abs_d1 <= (PW + 1)'(p1c_r)));
  assign lsum    = lu_r + lv_r;
  assign len_hit = lsum <= (PW + 1)'(lw_r);
  assign ssum    = sa_r + sb_r;
  assign esum    = ea_r + eb_r;
  assign c5_end  = (ssum <= (PW + 1)'(rr_r)) || (esum <= (PW + 1)'(rr_r));
  assign dd      = da_r + db_r;
  assign nsum    = na_r + nb_r;
  assign c5_go   = (dd != '0) && !(nsum < 0) && !(nsum > dd);
  assign cr      = ka_r - kb_r;
  assign cra     = (cr < 0) ? -cr : cr;

  // all three operands are non-negative; split into halves for the wide products
  assign cm = MW'($unsigned(cra));
  assign rm = MW'($unsigned(rr_r));
  assign dm = MW'($unsigned(dd));

  always_comb begin
    case (s1_t_r) inside
      PCT_PT_PT:                                 pre = s1_c0_r;
      PCT_PT_SEG:                                pre = c1_hit;
      PCT_PT_CIRC, PCT_CIRC_CIRC, PCT_CIRC_RECT: pre = len_hit;
      PCT_PT_RECT:                               pre = s1_c3_r;
      PCT_RECT_RECT:                             pre = s1_c9_r;
      default:                                   pre = 1'b0;
    endcase
  end

  logic          s2_v_r, s2_pre_r, s2_end_r, s2_go_r;
  pct_pair_t     s2_t_r;
  logic [MW-1:0] cc_ll_r, cc_lh_r, cc_hh_r, rd_ll_r, rd_lh_r, rd_hl_r, rd_hh_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_t_r   <= s1_t_r;
      s2_pre_r <= pre;
      s2_end_r <= c5_end;
      s2_go_r  <= c5_go;
      cc_ll_r  <= cm[HW-1:0] * cm[HW-1:0];
      cc_lh_r  <= cm[HW-1:0] * cm[MW-1:HW];
      cc_hh_r  <= cm[MW-1:HW] * cm[MW-1:HW];
      rd_ll_r  <= rm[HW-1:0] * dm[HW-1:0];
      rd_lh_r  <= rm[HW-1:0] * dm[MW-1:HW];
      rd_hl_r  <= rm[MW-1:HW] * dm[HW-1:0];
      rd_hh_r  <= rm[MW-1:HW] * dm[MW-1:HW];
    end
  end

  // recombine partial products: cross squared against r^2 * |d|^2
  logic [2*MW-1:0] nn, rdd;

  assign nn  = {cc_hh_r, cc_ll_r} + ((2 * MW)'(cc_lh_r) << (HW + 1));
  assign rdd = {rd_hh_r, rd_ll_r} + ((2 * MW)'(rd_lh_r) << HW) +
               ((2 * MW)'(rd_hl_r) << HW);

  // ---- result register ----
  logic hit_nxt, out_valid_r, out_hit_r;

  always_comb begin
    case (s2_t_r)
      PCT_SEG_SEG:  hit_nxt = ss[0];
      PCT_SEG_RECT: hit_nxt = |ss;
      PCT_SEG_CIRC: hit_nxt = s2_end_r || (s2_go_r && (nn <= rdd));
      default:      hit_nxt = s2_pre_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= !q_st.empty;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r <= hit_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

`default_nettype wire

/* rtl/core/primitive_collision_test_2d.sv */
// ----------------------------------------------------------------------------
// primitive_collision_test_2d
// Point / segment / circle / box pair intersection test, one hit bit a query.
// ----------------------------------------------------------------------------
// Path: the front register loads at the transfer, then come the queue, the
//   product stage, the compare stage and the result register.
// Throughput: one query per cycle while out_stall is low; the 4-entry queue
//   decouples the input stage from the product/compare pipeline.
// Reset: synchronous active-low; empties pipeline and queue, epsilon to 1.
`default_nettype none

module primitive_collision_test_2d import pct_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [2:0]                    paddr,
  input  wire  [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [3:0]                    in_req_type,
  input  wire  signed [COORD_WIDTH-1:0] in_a_x0,
  input  wire  signed [COORD_WIDTH-1:0] in_a_y0,
  input  wire  signed [COORD_WIDTH-1:0] in_a_x1,
  input  wire  signed [COORD_WIDTH-1:0] in_a_y1,
  input  wire  signed [COORD_WIDTH-1:0] in_b_x0,
  input  wire  signed [COORD_WIDTH-1:0] in_b_y0,
  input  wire  signed [COORD_WIDTH-1:0] in_b_x1,
  input  wire  signed [COORD_WIDTH-1:0] in_b_y1,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic                          out_hit
);

  localparam int EW    = COORD_WIDTH + 4;
  localparam int IW    = 4 + 16 * EW;
  localparam int QDEPTH = 4;

  logic [EPS_W-1:0] eps_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_EPS) ? {{(32 - EPS_W){1'b0}}, eps_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_wr && paddr[2] == REG_EPS) begin
      eps_r <= pwdata[EPS_W-1:0];
    end
  end

  pct_qstat_t    q_st;
  logic          q_push, q_pop, f_valid;
  logic [IW-1:0] f_item, q_rdata;

  pct_front #(.W(COORD_WIDTH), .EW(EW), .IW(IW)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_a_x0(in_a_x0), .in_a_y0(in_a_y0), .in_a_x1(in_a_x1), .in_a_y1(in_a_y1),
    .in_b_x0(in_b_x0), .in_b_y0(in_b_y0), .in_b_x1(in_b_x1), .in_b_y1(in_b_y1),
    .q_st(q_st), .push(q_push), .f_valid(f_valid), .item(f_item)
  );

  pct_queue #(.WIDTH(IW), .DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(f_item),
    .pop(q_pop), .rdata(q_rdata), .stat(q_st)
  );

  pct_back #(.W(COORD_WIDTH), .FRAC(FRAC_BITS), .EW(EW), .IW(IW)) u_back (
    .clk(clk), .rst_n(rst_n), .eps(eps_r), .q_st(q_st), .q_rdata(q_rdata),
    .q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit)
  );

  // an accepted transfer always lands in the front register
  a_front_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> f_valid)
    else $error("front register lost an accepted transfer");

  // front holds its item while the queue is full
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid && q_st.full |=> f_valid)
    else $error("front item dropped while queue full");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    q_st.full |-> !q_st.empty)
    else $error("queue full and empty together");

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb - primitive_collision_test_2d testbench
// Drives pair queries in bursts against a randomly stalling receiver, predicts
// the hit bit with exact wide integer arithmetic and checks every result in
// order. The epsilon register is swept across several values between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pct_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [3:0] kind;
    int         ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } query_t;

  class hit_scoreboard;
    bit hits_due[$];
    int errors;
    int checked;

    function void note_query(bit predicted);
      hits_due.push_back(predicted);
    endfunction

    function void check_hit(bit actual);
      bit want;
      if (hits_due.size() == 0) begin
        $error("result with nothing expected: hit=%0d", actual);
        errors++;
        return;
      end
      want = hits_due.pop_front();
      checked++;
      if (want !== actual) begin
        $error("field hit: expected %0d, actual %0d", want, actual);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid, in_stall, out_valid, out_stall, out_hit;
  logic [3:0]  in_req_type;
  logic signed [31:0] in_a_x0, in_a_y0, in_a_x1, in_a_y1;
  logic signed [31:0] in_b_x0, in_b_y0, in_b_x1, in_b_y1;

  primitive_collision_test_2d u_dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_a_x0(in_a_x0), .in_a_y0(in_a_y0), .in_a_x1(in_a_x1), .in_a_y1(in_a_y1),
    .in_b_x0(in_b_x0), .in_b_y0(in_b_y0), .in_b_x1(in_b_x1), .in_b_y1(in_b_y1),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit)
  );

  hit_scoreboard sb = new();
  longint eps = 1;
  int     accepted = 0;
  int     cycles = 0;
  bit     long_hold = 0;
  bit     long_hold_done = 0;
  int     type_seen[16];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic wide_t mulw(longint a, longint b);
    wide_t x, y;
    x = a;
    y = b;
    return x * y;
  endfunction

  function automatic wide_t crossw(longint ax, longint ay, longint bx, longint by);
    return mulw(ax, by) - mulw(ay, bx);
  endfunction

  function automatic wide_t sq2(longint x, longint y);
    return mulw(x, x) + mulw(y, y);
  endfunction

  function automatic wide_t absw(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit is_near0(longint d);
    return ((d < 0) ? -d : d) <= eps;
  endfunction

  function automatic bit in_span(longint a, longint b, longint v);
    return ((a < b) ? a : b) <= v && v <= ((a > b) ? a : b);
  endfunction

  function automatic bit in_box(longint ax, longint ay, longint bx, longint by,
                                longint px, longint py);
    return in_span(ax, bx, px) && in_span(ay, by, py);
  endfunction

  function automatic bit ratio_in_unit(wide_t n, wide_t c);
    if (c >= 0) return n >= 0 && n <= c;
    return n >= c && n <= 0;
  endfunction

  function automatic bit segs_cross(longint x1, longint y1, longint x2, longint y2,
                                    longint x3, longint y3, longint x4, longint y4,
                                    wide_t thr);
    longint ax, ay, bx, by, cx, cy;
    wide_t c;
    ax = x2 - x1; ay = y2 - y1; bx = x4 - x3; by = y4 - y3;
    cx = x1 - x3; cy = y1 - y3;
    c = crossw(ax, ay, bx, by);
    // parallel: endpoint-in-bounding-box rule
    if (absw(c) <= thr)
      return in_box(x1, y1, x2, y2, x3, y3) || in_box(x1, y1, x2, y2, x4, y4) ||
             in_box(x3, y3, x4, y4, x1, y1) || in_box(x3, y3, x4, y4, x2, y2);
    return ratio_in_unit(crossw(bx, by, cx, cy), c) &&
           ratio_in_unit(crossw(ax, ay, cx, cy), c);
  endfunction

  function automatic bit point_on_seg(longint px, longint py, longint sx, longint sy,
                                      longint ex, longint ey);
    longint dx, dy;
    dx = ex - sx; dy = ey - sy;
    if (is_near0(sx - ex)) return is_near0(sx - px) && in_span(sy, ey, py);
    if (is_near0(sy - ey)) return is_near0(sy - py) && in_span(sx, ex, px);
    if (!in_span(sx, ex, px)) return 0;
    return absw(mulw(dy, px - sx) - mulw(py - sy, dx)) <=
           mulw(eps, (dx < 0) ? -dx : dx);
  endfunction

  function automatic bit seg_hits_circle(longint sx, longint sy, longint ex, longint ey,
                                         longint cx, longint cy, longint r);
    wide_t r2, dd, n;
    longint dx, dy;
    r2 = mulw(r, r);
    dx = ex - sx; dy = ey - sy;
    if (sq2(sx - cx, sy - cy) <= r2 || sq2(ex - cx, ey - cy) <= r2) return 1;
    dd = sq2(dx, dy);
    if (dd == 0) return 0;
    n = mulw(cx - sx, dx) + mulw(cy - sy, dy);
    if (n < 0 || n > dd) return 0;
    n = crossw(dx, dy, cx - sx, cy - sy);
    return n * n <= r2 * dd;
  endfunction

  function automatic bit seg_hits_box(longint sx, longint sy, longint ex, longint ey,
                                      longint cx, longint cy, longint w, longint h);
    longint x0, x1, y0, y1, ax, ay, bx, by;
    wide_t thr;
    x0 = 2 * cx - w; x1 = 2 * cx + w; y0 = 2 * cy - h; y1 = 2 * cy + h;
    ax = 2 * sx; ay = 2 * sy; bx = 2 * ex; by = 2 * ey;
    thr = mulw(eps, 64'sd262144);
    return segs_cross(ax, ay, bx, by, x0, y0, x1, y0, thr) ||
           segs_cross(ax, ay, bx, by, x1, y0, x1, y1, thr) ||
           segs_cross(ax, ay, bx, by, x1, y1, x0, y1, thr) ||
           segs_cross(ax, ay, bx, by, x0, y1, x0, y0, thr);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit predict_hit(query_t q);
    longint ax, ay, ax1, ay1, bx, by, bx1, by1, qx, qy;
    ax = q.ax0; ay = q.ay0; ax1 = q.ax1; ay1 = q.ay1;
    bx = q.bx0; by = q.by0; bx1 = q.bx1; by1 = q.by1;
    case (q.kind)
      PCT_PT_PT:     return ax == bx && ay == by;
      PCT_PT_SEG:    return point_on_seg(ax, ay, bx, by, bx1, by1);
      PCT_PT_CIRC:   return sq2(ax - bx, ay - by) <= mulw(bx1, bx1);
      PCT_PT_RECT:   return 2 * bx - bx1 <= 2 * ax && 2 * ax <= 2 * bx + bx1 &&
                            2 * by - by1 <= 2 * ay && 2 * ay <= 2 * by + by1;
      PCT_SEG_SEG:   return segs_cross(ax, ay, ax1, ay1, bx, by, bx1, by1,
                                       mulw(eps, 64'sd65536));
      PCT_SEG_CIRC:  return seg_hits_circle(ax, ay, ax1, ay1, bx, by, bx1);
      PCT_SEG_RECT:  return seg_hits_box(ax, ay, ax1, ay1, bx, by, bx1, by1);
      PCT_CIRC_CIRC: return sq2(bx - ax, by - ay) <= mulw(ax1 + bx1, ax1 + bx1);
      PCT_CIRC_RECT: begin
        qx = clamp(2 * ax, 2 * bx - bx1, 2 * bx + bx1);
        qy = clamp(2 * ay, 2 * by - by1, 2 * by + by1);
        return sq2(qx - 2 * ax, qy - 2 * ay) <= mulw(2 * ax1, 2 * ax1);
      end
      PCT_RECT_RECT: return 2 * bx - bx1 <= 2 * ax + ax1 && 2 * ax - ax1 <= 2 * bx + bx1 &&
                            2 * by - by1 <= 2 * ay + ay1 && 2 * ay - ay1 <= 2 * by + by1;
      default:       return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------- monitors
  always @(posedge clk) begin
    query_t q;
    cycles <= cycles + 1;
    if (rst_n && in_valid && !in_stall) begin
      q.kind = in_req_type;
      q.ax0 = in_a_x0; q.ay0 = in_a_y0; q.ax1 = in_a_x1; q.ay1 = in_a_y1;
      q.bx0 = in_b_x0; q.by0 = in_b_y0; q.bx1 = in_b_x1; q.by1 = in_b_y1;
      sb.note_query(predict_hit(q));
      type_seen[q.kind]++;
      accepted <= accepted + 1;
    end
    if (rst_n && out_valid && !out_stall) sb.check_hit(out_hit);
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("primitive_collision_test_2d: mismatch");
      $finish;
    end
  end

  // receiver: own stall pattern, plus one long hold-off on request
  initial begin
    int mode, run;
    out_stall = 1'b0;
    mode = 0;
    run = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        long_hold = 0;
        long_hold_done = 1;
      end
      if (run == 0) begin
        mode = $urandom_range(0, 3);
        run = $urandom_range(5, 60);
      end
      run--;
      case (mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 3) == 0);
        2: out_stall = ($urandom_range(0, 1) == 0);
        default: out_stall = ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic write_eps(logic [15:0] value);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0; paddr = {REG_EPS, 2'b00}; pwdata = {16'd0, value};
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    eps = value;
  endtask

  // leaves in_valid high on exit; caller drops it or drives the next transfer
  task automatic send_query(query_t q);
    int seen;
    in_valid = 1;
    in_req_type = q.kind;
    in_a_x0 = q.ax0; in_a_y0 = q.ay0; in_a_x1 = q.ax1; in_a_y1 = q.ay1;
    in_b_x0 = q.bx0; in_b_y0 = q.by0; in_b_x1 = q.bx1; in_b_y1 = q.by1;
    seen = accepted;
    do @(negedge clk); while (accepted == seen);
  endtask

  task automatic drain;
    in_valid = 0;
    while (sb.hits_due.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1, 2:    return $urandom_range(0, 16) - 8;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    q.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
    q.ax0 = pick_coord(); q.ay0 = pick_coord(); q.ax1 = pick_coord(); q.ay1 = pick_coord();
    q.bx0 = pick_coord(); q.by0 = pick_coord(); q.bx1 = pick_coord(); q.by1 = pick_coord();
    // sizes and radii mostly positive
    if ($urandom_range(0, 3) != 0) begin
      q.ax1 = (q.kind inside {PCT_CIRC_CIRC, PCT_CIRC_RECT, PCT_RECT_RECT})
              ? $urandom_range(0, 32'h0020_0000) : q.ax1;
      q.bx1 = (q.kind inside {PCT_PT_CIRC, PCT_PT_RECT, PCT_SEG_CIRC, PCT_SEG_RECT,
                              PCT_CIRC_CIRC, PCT_CIRC_RECT, PCT_RECT_RECT})
              ? $urandom_range(0, 32'h0020_0000) : q.bx1;
      q.ay1 = (q.kind == PCT_RECT_RECT) ? $urandom_range(0, 32'h0020_0000) : q.ay1;
      q.by1 = (q.kind inside {PCT_PT_RECT, PCT_SEG_RECT, PCT_CIRC_RECT, PCT_RECT_RECT})
              ? $urandom_range(0, 32'h0020_0000) : q.by1;
    end
    case ($urandom_range(0, 5))
      0: begin q.bx0 = q.ax0; q.by0 = q.ay0; end
      1: begin q.by1 = q.by0 + $urandom_range(0, 4) - 2; end  // near-horizontal
      2: begin q.bx1 = q.bx0 + $urandom_range(0, 4) - 2; end  // near-vertical
      3: if (q.kind == PCT_PT_SEG) begin
        q.bx1 = q.bx0 + 2 * ($urandom_range(0, 2000) - 1000);
        q.by1 = q.by0 + 2 * ($urandom_range(0, 2000) - 1000);
        q.ax0 = (q.bx0 + q.bx1) / 2; q.ay0 = (q.by0 + q.by1) / 2;
      end
      default: ;
    endcase
    return q;
  endfunction

  function automatic query_t mk(logic [3:0] k, int a0, int a1, int a2, int a3,
                                int b0, int b1, int b2, int b3);
    query_t q;
    q.kind = k;
    q.ax0 = a0; q.ay0 = a1; q.ax1 = a2; q.ay1 = a3;
    q.bx0 = b0; q.by0 = b1; q.bx1 = b2; q.by1 = b3;
    return q;
  endfunction

  task automatic random_burst_phase(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && left > 0) begin
        send_query(random_query());
        burst--; left--;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid = 0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    in_valid = 0;
  endtask

  initial begin
    query_t directed[$];
    int MAXI, MINI;
    MAXI = 32'h7fff_ffff;
    MINI = 32'h8000_0000;
    rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; in_req_type = '0;
    in_a_x0 = 0; in_a_y0 = 0; in_a_x1 = 0; in_a_y1 = 0;
    in_b_x0 = 0; in_b_y0 = 0; in_b_x1 = 0; in_b_y1 = 0;
    repeat (11) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: extremes, every pair code, named corner cases (reset epsilon)
    for (int k = 0; k < 16; k++) directed.push_back(mk(4'(k), MAXI, MINI, MAXI, MINI,
                                                         MINI, MAXI, MINI, MAXI));
    directed.push_back(mk(PCT_PT_PT, 5, 7, 0, 0, 5, 7, 0, 0));
    directed.push_back(mk(PCT_PT_SEG, 1, 50, 0, 0, 0, 0, 1, 100));          // vertical
    directed.push_back(mk(PCT_PT_SEG, 50, 1, 0, 0, 0, 0, 100, 1));          // horizontal
    directed.push_back(mk(PCT_PT_SEG, 300, 150, 0, 0, 0, 0, 200, 100));     // beyond span
    directed.push_back(mk(PCT_SEG_SEG, 0, 0, 100, 0, 50, 0, 200, 0));       // parallel
    directed.push_back(mk(PCT_SEG_CIRC, 10, 10, 10, 10, 0, 0, 5, 0));       // zero length
    directed.push_back(mk(PCT_SEG_RECT, -1, 0, 1, 0, 0, 0, 100, 100));      // inside box
    directed.push_back(mk(PCT_PT_CIRC, 3, 4, 0, 0, 0, 0, -5, 0));           // neg radius
    directed.push_back(mk(PCT_CIRC_RECT, 0, 0, 10, 0, 0, 0, -20, -20));     // neg size
    directed.push_back(mk(PCT_CIRC_CIRC, 0, 0, 0, 0, 0, 0, 0, 0));
    foreach (directed[i]) send_query(directed[i]);
    drain();

    // reset epsilon, with one long receiver hold-off to fill the queue
    long_hold = 1;
    random_burst_phase(250);
    while (!long_hold_done) @(negedge clk);
    drain();

    write_eps(16'd0);
    random_burst_phase(220);
    drain();
    write_eps(16'hffff);
    random_burst_phase(220);
    drain();
    write_eps(16'($urandom_range(2, 65534)));
    random_burst_phase(220);
    drain();
    write_eps(16'd16);
    random_burst_phase(200);
    drain();

    $display("covered %0d queries, %0d results checked, five epsilon settings",
             accepted, sb.checked);
    $display("unknown pair codes seen %0d times", type_seen[10] + type_seen[11] +
             type_seen[12] + type_seen[13] + type_seen[14] + type_seen[15]);
    if (sb.errors == 0 && sb.hits_due.size() == 0)
      $display("primitive_collision_test_2d: match");
    else
      $display("primitive_collision_test_2d: mismatch");
    $finish;
  end

endmodule
